FILE: hdl/srr_pkg.sv
package srr_pkg;

  // sizes
  localparam int MAX_SEQ  = 16;
  localparam int PAY_W    = 32;
  localparam int SEQ_W    = $clog2(MAX_SEQ);
  localparam int SPACE_W  = SEQ_W + 1;
  localparam int WIN_W    = 4;
  localparam int WIN_CAP  = 8;
  localparam int CNT_W    = $clog2(WIN_CAP + 1);

  typedef logic [SEQ_W-1:0]   seq_t;
  typedef logic [SPACE_W-1:0] space_t;
  typedef logic [WIN_W-1:0]   win_t;
  typedef logic [PAY_W-1:0]   pay_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // configuration register indexes
  typedef enum logic {
    REG_SEQ_SPACE   = 1'b0,
    REG_WINDOW_SIZE = 1'b1
  } reg_idx_t;

  // reset values of the registers
  localparam space_t SEQ_SPACE_RST   = space_t'(8);
  localparam win_t   WINDOW_SIZE_RST = win_t'(4);

  // result kinds
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN_RD,
    ST_RUN_OUT,
    ST_ACK
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic cap;       // capture the input request
    logic ld_ack;    // load ack result
    logic ld_pay;    // load delivery of the captured payload
    logic ld_rd;     // load delivery of the slot read data
    logic wr_slot;   // buffer captured payload, mark valid
    logic rd_slot;   // read slot at run index, clear its valid
    logic init_run;  // start a run after the base
    logic step_run;  // move the run index on
    logic set_base;  // base takes the run index
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ok;
    logic in_win;
    logic at_base;
    logic out_free;
    logic run_more;
  } status_t;

  // sequence number plus one, wrapped at the space
  function automatic seq_t seq_inc(input seq_t v, input space_t s);
    space_t n;
    n = {1'b0, v} + space_t'(1);
    return (n == s) ? '0 : n[SEQ_W-1:0];
  endfunction

endpackage

FILE: hdl/srr_if.sv
interface srr_in_if;
  import srr_pkg::*;

  logic valid;
  logic ready;
  seq_t seq_num;
  logic checksum_ok;
  pay_t payload;

  modport source (output valid, seq_num, checksum_ok, payload, input ready);
  modport sink   (input valid, seq_num, checksum_ok, payload, output ready);
endinterface

interface srr_out_if;
  import srr_pkg::*;

  logic valid;
  logic ready;
  logic kind;
  seq_t ack_num;
  pay_t data_out;
  logic last;

  modport source (output valid, kind, ack_num, data_out, last, input ready);
  modport sink   (input valid, kind, ack_num, data_out, last, output ready);
endinterface

FILE: hdl/srr_ctrl.sv
module srr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  srr_pkg::status_t sts,
  output srr_pkg::cmd_t    cmd
);
  import srr_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.ok) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          if (!sts.in_win) begin
            cmd.ld_ack = 1'b1;
            state_nxt  = ST_IDLE;
          end else if (sts.at_base) begin
            cmd.ld_pay   = 1'b1;
            cmd.init_run = 1'b1;
            state_nxt    = ST_RUN_RD;
          end else begin
            cmd.wr_slot = 1'b1;
            cmd.ld_ack  = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
      ST_RUN_RD: begin
        if (sts.run_more) begin
          cmd.rd_slot = 1'b1;
          state_nxt   = ST_RUN_OUT;
        end else begin
          state_nxt = ST_ACK;
        end
      end
      ST_RUN_OUT: begin
        if (sts.out_free) begin
          cmd.ld_rd    = 1'b1;
          cmd.step_run = 1'b1;
          state_nxt    = ST_RUN_RD;
        end
      end
      ST_ACK: begin
        if (sts.out_free) begin
          cmd.ld_ack   = 1'b1;
          cmd.set_base = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/srr_dp.sv
module srr_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  srr_pkg::reg_idx_t cfg_index,
  input  srr_pkg::space_t  cfg_wdata,
  input  srr_pkg::seq_t    in_seq,
  input  logic             in_ok,
  input  srr_pkg::pay_t    in_pay,
  input  srr_pkg::cmd_t    cmd,
  output srr_pkg::status_t sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_kind,
  output srr_pkg::seq_t    out_ack,
  output srr_pkg::pay_t    out_data,
  output logic             out_last
);
  import srr_pkg::*;

  space_t             seq_space_r;
  win_t               window_r;
  seq_t               base_r;
  logic [MAX_SEQ-1:0] valid_r;
  pay_t               slot_mem [MAX_SEQ];
  pay_t               rd_data_r;
  seq_t               seq_r;
  logic               ok_r;
  pay_t               pay_r;
  seq_t               idx_r;
  cnt_t               cnt_r;
  logic               ov_r;
  logic               kind_r;
  seq_t               ack_r;
  pay_t               data_r;
  logic               last_r;

  space_t s_eff;
  space_t w_req;
  space_t w_cap;
  space_t w_eff;
  space_t end_sum;
  seq_t   win_end;
  logic   in_win;
  logic   out_free;

  // effective space and window
  always_comb begin
    if (seq_space_r < space_t'(2)) begin
      s_eff = space_t'(2);
    end else if (seq_space_r > space_t'(MAX_SEQ)) begin
      s_eff = space_t'(MAX_SEQ);
    end else begin
      s_eff = seq_space_r;
    end
    w_req = (window_r == '0) ? space_t'(1) : {1'b0, window_r};
    w_cap = (s_eff < space_t'(WIN_CAP)) ? s_eff : space_t'(WIN_CAP);
    w_eff = (w_req > w_cap) ? w_cap : w_req;
  end

  // window membership of the captured sequence number
  always_comb begin
    end_sum = {1'b0, base_r} + w_eff;
    win_end = (end_sum >= s_eff) ? SEQ_W'(end_sum - s_eff) : end_sum[SEQ_W-1:0];
    if ({1'b0, seq_r} >= s_eff) begin
      in_win = 1'b0;
    end else if (base_r < win_end) begin
      in_win = (seq_r >= base_r) && (seq_r < win_end);
    end else begin
      in_win = (seq_r >= base_r) || (seq_r < win_end);
    end
  end

  assign out_free = !ov_r || out_ready;

  assign sts.ok       = ok_r;
  assign sts.in_win   = in_win;
  assign sts.at_base  = (seq_r == base_r);
  assign sts.out_free = out_free;
  assign sts.run_more = ({1'b0, cnt_r} < w_eff) && valid_r[idx_r];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_space_r <= SEQ_SPACE_RST;
      window_r    <= WINDOW_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEQ_SPACE:   seq_space_r <= cfg_wdata;
        REG_WINDOW_SIZE: window_r    <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // window base and slot valid bits, restarted by any register write
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      base_r  <= '0;
      valid_r <= '0;
    end else begin
      if (cmd.set_base) begin
        base_r <= idx_r;
      end
      if (cmd.wr_slot) begin
        valid_r[seq_r] <= 1'b1;
      end
      if (cmd.rd_slot) begin
        valid_r[idx_r] <= 1'b0;
      end
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_slot) begin
      slot_mem[seq_r] <= pay_r;
    end
    if (cmd.rd_slot) begin
      rd_data_r <= slot_mem[idx_r];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      seq_r <= in_seq;
      ok_r  <= in_ok;
      pay_r <= in_pay;
    end
  end

  // run index and count
  always_ff @(posedge clk) begin
    if (cmd.init_run) begin
      idx_r <= seq_inc(base_r, s_eff);
      cnt_r <= cnt_t'(1);
    end else if (cmd.step_run) begin
      idx_r <= seq_inc(idx_r, s_eff);
      cnt_r <= cnt_r + cnt_t'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.ld_ack || cmd.ld_pay || cmd.ld_rd) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_ack) begin
      kind_r <= KIND_ACK;
      ack_r  <= seq_r;
      data_r <= '0;
      last_r <= 1'b1;
    end else if (cmd.ld_pay || cmd.ld_rd) begin
      kind_r <= KIND_DELIVER;
      ack_r  <= '0;
      data_r <= cmd.ld_pay ? pay_r : rd_data_r;
      last_r <= 1'b0;
    end
  end

  assign out_valid = ov_r;
  assign out_kind  = kind_r;
  assign out_ack   = ack_r;
  assign out_data  = data_r;
  assign out_last  = last_r;

endmodule

FILE: hdl/selective_repeat_receiver.sv
// Selective repeat receiver.
// in_pkt carries one packet per request: seq_num, checksum_ok and payload.
// out_res carries results: acks (kind 0, ack_num) and deliveries (kind 1,
// data_out); last marks the ack that ends the results of one packet.
// cfg_we/cfg_index/cfg_wdata write seq_space (index 0) or window_size
// (index 1); either write restarts the window at base 0 with no slots held.
// Write them only while the block is idle.
// A corrupt packet gives nothing. An out-of-window or buffered packet is
// captured, checked, and its ack loaded into the output register once the
// output is free. A packet at the window base delivers its payload, then k
// contiguous buffered slots, then the ack, with the controller walking the
// slot memory one read and one result at a time.
// Reset sets seq_space 8, window_size 4, base 0 and clears all slot flags.
// A stalled out_res holds the result register; the controller waits and
// in_pkt stays not ready until the packet's work is done.
module selective_repeat_receiver (
  input  logic              clk,
  input  logic              rst_n,
  srr_in_if.sink            in_pkt,
  srr_out_if.source         out_res,
  input  logic              cfg_we,
  input  srr_pkg::reg_idx_t cfg_index,
  input  srr_pkg::space_t   cfg_wdata
);
  import srr_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // controller
  srr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pkt.valid),
    .in_ready (in_pkt.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  srr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_seq    (in_pkt.seq_num),
    .in_ok     (in_pkt.checksum_ok),
    .in_pay    (in_pkt.payload),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_kind  (out_res.kind),
    .out_ack   (out_res.ack_num),
    .out_data  (out_res.data_out),
    .out_last  (out_res.last)
  );

endmodule
